// ----- hdl/gmg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmg_pkg
// Shared types, widths and helpers of the grid mesh generator.
// ----------------------------------------------------------------------------
package gmg_pkg;

  localparam int GMG_DIM_W      = 24;  // extents and positions
  localparam int GMG_SIDE_W     = 11;  // row and column counts
  localparam int GMG_RC_W       = 10;  // row and column of a request
  localparam int GMG_IDX_W      = 20;  // vertex index
  localparam int GMG_UV_W       = 17;  // texture coordinate
  localparam int GMG_UV_SHIFT   = 16;  // 1.0 in texture units
  localparam int GMG_DVS_W      = 10;  // divisor, count minus one
  localparam int GMG_QUO_W      = 24;  // quotient bits
  localparam int GMG_DIVD_W     = GMG_QUO_W + GMG_DVS_W;
  localparam int GMG_DIV_BITS   = 2;   // quotient bits resolved per stage
  localparam int GMG_DIV_STAGES = GMG_QUO_W / GMG_DIV_BITS;

  localparam logic [GMG_SIDE_W-1:0] GMG_MAX_SIDE = 11'd1024;
  localparam logic [GMG_SIDE_W-1:0] GMG_MIN_SIDE = 11'd2;

  typedef enum logic {
    GMG_OP_VERTEX = 1'b0,
    GMG_OP_QUAD   = 1'b1
  } gmg_op_e;

  typedef enum logic [1:0] {
    GMG_REG_WIDTH = 2'd0,
    GMG_REG_DEPTH = 2'd1,
    GMG_REG_ROWS  = 2'd2,
    GMG_REG_COLS  = 2'd3
  } gmg_reg_e;

  // Control and index data that travels beside the divider lanes.
  typedef struct packed {
    logic                 valid;
    gmg_op_e              op;
    logic                 oor;
    logic [GMG_IDX_W-1:0] top;
    logic [GMG_IDX_W-1:0] bot;
  } gmg_sb_t;

  function automatic logic [GMG_SIDE_W-1:0] clamp_side(input logic [GMG_SIDE_W-1:0] v);
    logic [GMG_SIDE_W-1:0] r;
    if (v < GMG_MIN_SIDE) begin
      r = GMG_MIN_SIDE;
    end else if (v > GMG_MAX_SIDE) begin
      r = GMG_MAX_SIDE;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hdl/grid_mesh_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_mesh_generator
// Flat grid tessellator in the XZ plane: vertex positions and texture
// coordinates, or the two triangles of a quad, for a requested row and column.
//
//   Channel   Direction  Handshake          Words
//   request   in         start_i, busy_o    op_i, row_i, col_i
//   result    out        done_o             pos_x_o .. last_o
//   config    in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// A request is taken in any cycle with start_i high and busy_o low. Its first
// word passes a request register, a product stage and twelve divider
// stages resolving two quotient bits each, then the output register. Vertex
// requests flow at one per cycle unless a quad is pending; a quad
// request shows two words and holds busy_o high for one cycle while its
// second triangle goes out. The receiver cannot stall, so busy_o comes only
// from a pending quad. Reset clears all valid bits and loads the register
// defaults.
// ----------------------------------------------------------------------------
module grid_mesh_generator import gmg_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        op_i,
  input  logic [GMG_RC_W-1:0]         row_i,
  input  logic [GMG_RC_W-1:0]         col_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [GMG_DIM_W-1:0]        cfg_wdata_i,
  output logic                        done_o,
  output logic signed [GMG_DIM_W-1:0] pos_x_o,
  output logic signed [GMG_DIM_W-1:0] pos_z_o,
  output logic [GMG_UV_W-1:0]         tex_u_o,
  output logic [GMG_UV_W-1:0]         tex_v_o,
  output logic [GMG_IDX_W-1:0]        corner_a_o,
  output logic [GMG_IDX_W-1:0]        corner_b_o,
  output logic [GMG_IDX_W-1:0]        corner_c_o,
  output logic                        out_of_range_o,
  output logic                        last_o
);

  logic [GMG_DIM_W-1:0]  width_q, depth_q;
  logic [GMG_SIDE_W-1:0] rows_cnt_q, cols_cnt_q;
  logic [GMG_SIDE_W-1:0] rows, cols, rows_m1, cols_m1;

  logic                  adv;
  gmg_sb_t               sb_front;
  gmg_sb_t               sb_q [GMG_DIV_STAGES];
  logic [GMG_DIVD_W-1:0] divd_x, divd_z, divd_u, divd_v;
  logic [GMG_QUO_W-1:0]  quo_x, quo_z, quo_u, quo_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 24'd256;
      depth_q    <= 24'd256;
      rows_cnt_q <= GMG_MIN_SIDE;
      cols_cnt_q <= GMG_MIN_SIDE;
    end else if (cfg_we_i) begin
      unique case (gmg_reg_e'(cfg_idx_i))
        GMG_REG_WIDTH: width_q    <= cfg_wdata_i;
        GMG_REG_DEPTH: depth_q    <= cfg_wdata_i;
        GMG_REG_ROWS:  rows_cnt_q <= cfg_wdata_i[GMG_SIDE_W-1:0];
        GMG_REG_COLS:  cols_cnt_q <= cfg_wdata_i[GMG_SIDE_W-1:0];
        default:       width_q    <= width_q;
      endcase
    end
  end

  assign rows    = clamp_side(rows_cnt_q);
  assign cols    = clamp_side(cols_cnt_q);
  assign rows_m1 = rows - 11'd1;
  assign cols_m1 = cols - 11'd1;

  // The whole pipeline holds while a quad's second triangle goes out.
  assign adv = !busy_o;

  gmg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .start_i  (start_i),
    .op_i     (op_i),
    .row_i    (row_i),
    .col_i    (col_i),
    .width_i  (width_q),
    .depth_i  (depth_q),
    .rows_i   (rows),
    .cols_i   (cols),
    .sb_o     (sb_front),
    .divd_x_o (divd_x),
    .divd_z_o (divd_z),
    .divd_u_o (divd_u),
    .divd_v_o (divd_v)
  );

  gmg_div_pipe u_div_x (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (divd_x),
    .divisor_i  (cols_m1[GMG_DVS_W-1:0]),
    .quotient_o (quo_x)
  );

  gmg_div_pipe u_div_z (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (divd_z),
    .divisor_i  (rows_m1[GMG_DVS_W-1:0]),
    .quotient_o (quo_z)
  );

  gmg_div_pipe u_div_u (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (divd_u),
    .divisor_i  (cols_m1[GMG_DVS_W-1:0]),
    .quotient_o (quo_u)
  );

  gmg_div_pipe u_div_v (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (divd_v),
    .divisor_i  (rows_m1[GMG_DVS_W-1:0]),
    .quotient_o (quo_v)
  );

  // Control and indices keep step with the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < GMG_DIV_STAGES; s++) begin
        sb_q[s] <= '0;
      end
    end else if (adv) begin
      sb_q[0] <= sb_front;
      for (int s = 1; s < GMG_DIV_STAGES; s++) begin
        sb_q[s] <= sb_q[s-1];
      end
    end
  end

  gmg_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sb_i           (sb_q[GMG_DIV_STAGES-1]),
    .quo_x_i        (quo_x),
    .quo_z_i        (quo_z),
    .quo_u_i        (quo_u),
    .quo_v_i        (quo_v),
    .width_i        (width_q),
    .depth_i        (depth_q),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .pos_x_o        (pos_x_o),
    .pos_z_o        (pos_z_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .corner_a_o     (corner_a_o),
    .corner_b_o     (corner_b_o),
    .corner_c_o     (corner_c_o),
    .out_of_range_o (out_of_range_o),
    .last_o         (last_o)
  );

endmodule

// ----- hdl/gmg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmg_front
// Request register with range check, then the product stage that forms the
// dividends and the vertex indices of a quad.
// ----------------------------------------------------------------------------
module gmg_front import gmg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  start_i,
  input  logic                  op_i,
  input  logic [GMG_RC_W-1:0]   row_i,
  input  logic [GMG_RC_W-1:0]   col_i,
  input  logic [GMG_DIM_W-1:0]  width_i,
  input  logic [GMG_DIM_W-1:0]  depth_i,
  input  logic [GMG_SIDE_W-1:0] rows_i,
  input  logic [GMG_SIDE_W-1:0] cols_i,
  output gmg_sb_t               sb_o,
  output logic [GMG_DIVD_W-1:0] divd_x_o,
  output logic [GMG_DIVD_W-1:0] divd_z_o,
  output logic [GMG_DIVD_W-1:0] divd_u_o,
  output logic [GMG_DIVD_W-1:0] divd_v_o
);

  logic                valid_a_q;
  gmg_op_e             op_a_q;
  logic                oor_a_q;
  logic [GMG_RC_W-1:0] row_a_q, col_a_q;
  logic                oor_a_d;

  gmg_sb_t               sb_q, sb_d;
  logic [GMG_DIVD_W-1:0] divd_x_q, divd_z_q, divd_u_q, divd_v_q;
  logic [GMG_DIVD_W-1:0] divd_x_d, divd_z_d, divd_u_d, divd_v_d;
  logic [GMG_SIDE_W+GMG_RC_W-1:0] top_full, bot_full;

  always_comb begin
    if (gmg_op_e'(op_i) == GMG_OP_QUAD) begin
      // A quad needs a further row and column beyond its own.
      oor_a_d = ({1'b0, row_i} >= (rows_i - 11'd1)) || ({1'b0, col_i} >= (cols_i - 11'd1));
    end else begin
      oor_a_d = ({1'b0, row_i} >= rows_i) || ({1'b0, col_i} >= cols_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_a_q  <= gmg_op_e'(op_i);
      oor_a_q <= oor_a_d;
      row_a_q <= row_i;
      col_a_q <= col_i;
    end
  end

  always_comb begin
    top_full = (GMG_SIDE_W+GMG_RC_W)'(row_a_q) * (GMG_SIDE_W+GMG_RC_W)'(cols_i)
             + (GMG_SIDE_W+GMG_RC_W)'(col_a_q);
    bot_full = (GMG_SIDE_W+GMG_RC_W)'({1'b0, row_a_q} + 11'd1)
             * (GMG_SIDE_W+GMG_RC_W)'(cols_i)
             + (GMG_SIDE_W+GMG_RC_W)'(col_a_q);
    sb_d.valid = valid_a_q;
    sb_d.op    = op_a_q;
    sb_d.oor   = oor_a_q;
    sb_d.top   = top_full[GMG_IDX_W-1:0];
    sb_d.bot   = bot_full[GMG_IDX_W-1:0];
    divd_x_d   = GMG_DIVD_W'(col_a_q) * GMG_DIVD_W'(width_i);
    divd_z_d   = GMG_DIVD_W'(row_a_q) * GMG_DIVD_W'(depth_i);
    divd_u_d   = GMG_DIVD_W'({col_a_q, {GMG_UV_SHIFT{1'b0}}});
    divd_v_d   = GMG_DIVD_W'({row_a_q, {GMG_UV_SHIFT{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q <= '0;
    end else if (en_i) begin
      sb_q <= sb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      divd_x_q <= divd_x_d;
      divd_z_q <= divd_z_d;
      divd_u_q <= divd_u_d;
      divd_v_q <= divd_v_d;
    end
  end

  assign sb_o     = sb_q;
  assign divd_x_o = divd_x_q;
  assign divd_z_o = divd_z_q;
  assign divd_u_o = divd_u_q;
  assign divd_v_o = divd_v_q;

endmodule

// ----- hdl/gmg_div_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmg_div_pipe
// Pipelined restoring divider, two quotient bits per stage. The quotient
// is known to fit its width, so the upper dividend bits seed the remainder.
// ----------------------------------------------------------------------------
module gmg_div_pipe import gmg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [GMG_DIVD_W-1:0] dividend_i,
  input  logic [GMG_DVS_W-1:0]  divisor_i,
  output logic [GMG_QUO_W-1:0]  quotient_o
);

  logic [GMG_DVS_W-1:0] rem_q [GMG_DIV_STAGES];
  logic [GMG_QUO_W-1:0] low_q [GMG_DIV_STAGES];
  logic [GMG_QUO_W-1:0] quo_q [GMG_DIV_STAGES];
  logic [GMG_DVS_W-1:0] rem_d [GMG_DIV_STAGES];
  logic [GMG_QUO_W-1:0] low_d [GMG_DIV_STAGES];
  logic [GMG_QUO_W-1:0] quo_d [GMG_DIV_STAGES];

  always_comb begin
    logic [GMG_DVS_W-1:0] rem;
    logic [GMG_QUO_W-1:0] low;
    logic [GMG_QUO_W-1:0] quo;
    logic [GMG_DVS_W:0]   trial;
    for (int s = 0; s < GMG_DIV_STAGES; s++) begin
      if (s == 0) begin
        rem = dividend_i[GMG_DIVD_W-1:GMG_QUO_W];
        low = dividend_i[GMG_QUO_W-1:0];
        quo = '0;
      end else begin
        rem = rem_q[s-1];
        low = low_q[s-1];
        quo = quo_q[s-1];
      end
      for (int b = 0; b < GMG_DIV_BITS; b++) begin
        trial = {rem, low[GMG_QUO_W-1]};
        low   = {low[GMG_QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          trial = trial - {1'b0, divisor_i};
          quo   = {quo[GMG_QUO_W-2:0], 1'b1};
        end else begin
          quo   = {quo[GMG_QUO_W-2:0], 1'b0};
        end
        rem = trial[GMG_DVS_W-1:0];
      end
      rem_d[s] = rem;
      low_d[s] = low;
      quo_d[s] = quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < GMG_DIV_STAGES; s++) begin
        rem_q[s] <= rem_d[s];
        low_q[s] <= low_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quotient_o = quo_q[GMG_DIV_STAGES-1];

endmodule

// ----- hdl/gmg_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmg_out
// Result formation and output register. A quad leaves its second triangle
// in a holding register and stalls the pipeline while that triangle goes out.
// ----------------------------------------------------------------------------
module gmg_out import gmg_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gmg_sb_t                     sb_i,
  input  logic [GMG_QUO_W-1:0]        quo_x_i,
  input  logic [GMG_QUO_W-1:0]        quo_z_i,
  input  logic [GMG_QUO_W-1:0]        quo_u_i,
  input  logic [GMG_QUO_W-1:0]        quo_v_i,
  input  logic [GMG_DIM_W-1:0]        width_i,
  input  logic [GMG_DIM_W-1:0]        depth_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic signed [GMG_DIM_W-1:0] pos_x_o,
  output logic signed [GMG_DIM_W-1:0] pos_z_o,
  output logic [GMG_UV_W-1:0]         tex_u_o,
  output logic [GMG_UV_W-1:0]         tex_v_o,
  output logic [GMG_IDX_W-1:0]        corner_a_o,
  output logic [GMG_IDX_W-1:0]        corner_b_o,
  output logic [GMG_IDX_W-1:0]        corner_c_o,
  output logic                        out_of_range_o,
  output logic                        last_o
);

  logic pending_q, pending_d;
  logic done_q, done_d;
  logic fire;

  logic [GMG_IDX_W-1:0] pend_a_q, pend_b_q, pend_c_q;
  logic [GMG_DIM_W-1:0] pos_x_q, pos_z_q, pos_x_d, pos_z_d;
  logic [GMG_UV_W-1:0]  tex_u_q, tex_v_q, tex_u_d, tex_v_d;
  logic [GMG_IDX_W-1:0] ca_q, cb_q, cc_q, ca_d, cb_d, cc_d;
  logic                 oor_q, last_q, oor_d, last_d;

  assign fire      = sb_i.valid && !pending_q;
  assign done_d    = fire || pending_q;
  assign pending_d = fire && (sb_i.op == GMG_OP_QUAD) && !sb_i.oor;

  always_comb begin
    pos_x_d = '0;
    pos_z_d = '0;
    tex_u_d = '0;
    tex_v_d = '0;
    ca_d    = '0;
    cb_d    = '0;
    cc_d    = '0;
    oor_d   = 1'b0;
    last_d  = 1'b1;
    priority if (pending_q) begin
      ca_d = pend_a_q;
      cb_d = pend_b_q;
      cc_d = pend_c_q;
    end else if (sb_i.oor) begin
      oor_d = 1'b1;
    end else if (sb_i.op == GMG_OP_QUAD) begin
      ca_d   = sb_i.top;
      cb_d   = sb_i.top + 20'd1;
      cc_d   = sb_i.bot;
      last_d = 1'b0;
    end else begin
      // Positions wrap in 24 bits; the grid is centred by half the extent.
      pos_x_d = quo_x_i - {1'b0, width_i[GMG_DIM_W-1:1]};
      pos_z_d = {1'b0, depth_i[GMG_DIM_W-1:1]} - quo_z_i;
      tex_u_d = quo_u_i[GMG_UV_W-1:0];
      tex_v_d = quo_v_i[GMG_UV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      pending_q <= pending_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pend_a_q <= sb_i.bot;
      pend_b_q <= sb_i.top + 20'd1;
      pend_c_q <= sb_i.bot + 20'd1;
    end
    if (done_d) begin
      pos_x_q <= pos_x_d;
      pos_z_q <= pos_z_d;
      tex_u_q <= tex_u_d;
      tex_v_q <= tex_v_d;
      ca_q    <= ca_d;
      cb_q    <= cb_d;
      cc_q    <= cc_d;
      oor_q   <= oor_d;
      last_q  <= last_d;
    end
  end

  assign busy_o         = pending_q;
  assign done_o         = done_q;
  assign pos_x_o        = signed'(pos_x_q);
  assign pos_z_o        = signed'(pos_z_q);
  assign tex_u_o        = tex_u_q;
  assign tex_v_o        = tex_v_q;
  assign corner_a_o     = ca_q;
  assign corner_b_o     = cb_q;
  assign corner_c_o     = cc_q;
  assign out_of_range_o = oor_q;
  assign last_o         = last_q;

  // While the second triangle waits, the first one is on the outputs.
  a_pending_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> (done_q && !last_q && !oor_q))
    else $error("second triangle pending without first triangle shown");

  a_first_then_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !last_q) |=> (done_q && last_q && !oor_q))
    else $error("first triangle not followed by second triangle");

  a_stall_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |=> !pending_q)
    else $error("pipeline stalled for more than one cycle");

  a_range_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && oor_q) |-> (last_q && ca_q == '0 && pos_x_q == '0 && tex_u_q == '0))
    else $error("range error word carries data");

endmodule

// ----- verif/grid_mesh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_mesh_checker
// Watches the request, configuration and result ports of the grid mesh
// generator. It keeps its own copy of the grid registers and works out the
// words each accepted request must produce. Each result word is compared
// field by field with the oldest outstanding word.
// ----------------------------------------------------------------------------
module grid_mesh_checker import gmg_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic                        op_i,
  input  logic [GMG_RC_W-1:0]         row_i,
  input  logic [GMG_RC_W-1:0]         col_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [GMG_DIM_W-1:0]        cfg_wdata_i,
  input  logic                        done_i,
  input  logic signed [GMG_DIM_W-1:0] pos_x_i,
  input  logic signed [GMG_DIM_W-1:0] pos_z_i,
  input  logic [GMG_UV_W-1:0]         tex_u_i,
  input  logic [GMG_UV_W-1:0]         tex_v_i,
  input  logic [GMG_IDX_W-1:0]        corner_a_i,
  input  logic [GMG_IDX_W-1:0]        corner_b_i,
  input  logic [GMG_IDX_W-1:0]        corner_c_i,
  input  logic                        out_of_range_i,
  input  logic                        last_i,
  output int                          mismatch_count_o,
  output int                          pending_o
);

  typedef struct packed {
    logic signed [GMG_DIM_W-1:0] pos_x;
    logic signed [GMG_DIM_W-1:0] pos_z;
    logic [GMG_UV_W-1:0]         tex_u;
    logic [GMG_UV_W-1:0]         tex_v;
    logic [GMG_IDX_W-1:0]        corner_a;
    logic [GMG_IDX_W-1:0]        corner_b;
    logic [GMG_IDX_W-1:0]        corner_c;
    logic                        oor;
    logic                        last;
  } mesh_word_t;

  mesh_word_t           expected_words[$];
  mesh_word_t           got;
  mesh_word_t           want;
  logic [GMG_DIM_W-1:0] grid_width;
  logic [GMG_DIM_W-1:0] grid_depth;
  logic [GMG_SIDE_W-1:0] row_count;
  logic [GMG_SIDE_W-1:0] col_count;
  int                   mismatches = 0;
  int                   pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  // Counts outside the supported range are pulled back to the nearest limit.
  function automatic longint unsigned usable_side(input logic [GMG_SIDE_W-1:0] v);
    longint unsigned s;
    s = 64'(v);
    if (s < 2) s = 2;
    if (s > 1024) s = 1024;
    return s;
  endfunction

  task automatic tessellate(input gmg_op_e op, input logic [GMG_RC_W-1:0] r,
                            input logic [GMG_RC_W-1:0] c);
    longint unsigned rows, cols, ru, cu, top, bot;
    longint          x, z;
    mesh_word_t      w;
    rows = usable_side(row_count);
    cols = usable_side(col_count);
    ru   = 64'(r);
    cu   = 64'(c);
    w    = '0;
    if (op == GMG_OP_VERTEX) begin
      if (ru >= rows || cu >= cols) begin
        w.oor  = 1'b1;
        w.last = 1'b1;
      end else begin
        x = longint'((cu * grid_width) / (cols - 1)) - longint'(grid_width >> 1);
        z = longint'(grid_depth >> 1) - longint'((ru * grid_depth) / (rows - 1));
        w.pos_x = x[GMG_DIM_W-1:0];
        w.pos_z = z[GMG_DIM_W-1:0];
        w.tex_u = GMG_UV_W'((cu * 65536) / (cols - 1));
        w.tex_v = GMG_UV_W'((ru * 65536) / (rows - 1));
        w.last  = 1'b1;
      end
      expected_words = {expected_words, w};
    end else begin
      if (ru >= rows - 1 || cu >= cols - 1) begin
        w.oor  = 1'b1;
        w.last = 1'b1;
        expected_words = {expected_words, w};
      end else begin
        top = ru * cols + cu;
        bot = (ru + 1) * cols + cu;
        w.corner_a = GMG_IDX_W'(top);
        w.corner_b = GMG_IDX_W'(top + 1);
        w.corner_c = GMG_IDX_W'(bot);
        expected_words = {expected_words, w};
        w.corner_a = GMG_IDX_W'(bot);
        w.corner_b = GMG_IDX_W'(top + 1);
        w.corner_c = GMG_IDX_W'(bot + 1);
        w.last     = 1'b1;
        expected_words = {expected_words, w};
      end
    end
  endtask

  task automatic compare_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width = 24'd256;
      grid_depth = 24'd256;
      row_count  = GMG_MIN_SIDE;
      col_count  = GMG_MIN_SIDE;
      expected_words.delete();
      pending = 0;
    end else begin
      if (done_i) begin
        got = '{pos_x_i, pos_z_i, tex_u_i, tex_v_i, corner_a_i, corner_b_i,
                corner_c_i, out_of_range_i, last_i};
        if (expected_words.size() == 0) begin
          $display("%0t: result word expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          compare_field("pos_x", want.pos_x, got.pos_x);
          compare_field("pos_z", want.pos_z, got.pos_z);
          compare_field("tex_u", want.tex_u, got.tex_u);
          compare_field("tex_v", want.tex_v, got.tex_v);
          compare_field("corner_a", want.corner_a, got.corner_a);
          compare_field("corner_b", want.corner_b, got.corner_b);
          compare_field("corner_c", want.corner_c, got.corner_c);
          compare_field("out_of_range", want.oor, got.oor);
          compare_field("last", want.last, got.last);
        end
      end
      if (cfg_we_i) begin
        case (gmg_reg_e'(cfg_idx_i))
          GMG_REG_WIDTH: grid_width = cfg_wdata_i;
          GMG_REG_DEPTH: grid_depth = cfg_wdata_i;
          GMG_REG_ROWS:  row_count  = cfg_wdata_i[GMG_SIDE_W-1:0];
          GMG_REG_COLS:  col_count  = cfg_wdata_i[GMG_SIDE_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        tessellate(gmg_op_e'(op_i), row_i, col_i);
      end
      pending = expected_words.size();
    end
  end

endmodule

// ----- verif/tb_grid_mesh_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_mesh_generator
// Drives vertex and quad requests into the grid mesh generator under a range
// of grid settings, including counts that must be clamped and the widest
// extents. A directed opening is followed by random requests, mostly inside
// the grid, with random gaps. The checker beside the block scores every word.
// ----------------------------------------------------------------------------
module tb_grid_mesh_generator;
  import gmg_pkg::*;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic                        op_i = 1'b0;
  logic [GMG_RC_W-1:0]         row_i = '0;
  logic [GMG_RC_W-1:0]         col_i = '0;
  logic                        cfg_we_i = 1'b0;
  logic [1:0]                  cfg_idx_i = '0;
  logic [GMG_DIM_W-1:0]        cfg_wdata_i = '0;
  logic                        done_o;
  logic signed [GMG_DIM_W-1:0] pos_x_o;
  logic signed [GMG_DIM_W-1:0] pos_z_o;
  logic [GMG_UV_W-1:0]         tex_u_o;
  logic [GMG_UV_W-1:0]         tex_v_o;
  logic [GMG_IDX_W-1:0]        corner_a_o;
  logic [GMG_IDX_W-1:0]        corner_b_o;
  logic [GMG_IDX_W-1:0]        corner_c_o;
  logic                        out_of_range_o;
  logic                        last_o;
  int                          mismatch_count;
  int                          pending;

  // Effective grid size, used only to aim requests inside the grid.
  int                          rows_eff = 2;
  int                          cols_eff = 2;

  grid_mesh_generator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .pos_x_o        (pos_x_o),
    .pos_z_o        (pos_z_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .corner_a_o     (corner_a_o),
    .corner_b_o     (corner_b_o),
    .corner_c_o     (corner_c_o),
    .out_of_range_o (out_of_range_o),
    .last_o         (last_o)
  );

  grid_mesh_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .op_i             (op_i),
    .row_i            (row_i),
    .col_i            (col_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_i           (done_o),
    .pos_x_i          (pos_x_o),
    .pos_z_i          (pos_z_o),
    .tex_u_i          (tex_u_o),
    .tex_v_i          (tex_v_o),
    .corner_a_i       (corner_a_o),
    .corner_b_i       (corner_b_o),
    .corner_c_i       (corner_c_o),
    .out_of_range_i   (out_of_range_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // Holds the word on the inputs until the block takes it.
  task automatic send_request(input gmg_op_e op, input int r, input int c);
    @(negedge clk_i);
    start_i <= 1'b1;
    op_i    <= op;
    row_i   <= GMG_RC_W'(r);
    col_i   <= GMG_RC_W'(c);
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      op_i    <= 1'($urandom_range(0, 1));
      row_i   <= GMG_RC_W'($urandom);
      col_i   <= GMG_RC_W'($urandom);
    end
  endtask

  // Waits for every outstanding word, then for the pipeline depth.
  task automatic settle();
    pause(1);
    for (int k = 0; k < 4000 && pending != 0; k++) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input gmg_reg_e idx, input logic [GMG_DIM_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  function automatic int side_of(input logic [GMG_DIM_W-1:0] v);
    int s;
    s = int'(v[GMG_SIDE_W-1:0]);
    if (s < 2) s = 2;
    if (s > 1024) s = 1024;
    return s;
  endfunction

  task automatic load_grid(input logic [GMG_DIM_W-1:0] w, input logic [GMG_DIM_W-1:0] d,
                           input logic [GMG_DIM_W-1:0] r, input logic [GMG_DIM_W-1:0] c);
    settle();
    write_reg(GMG_REG_WIDTH, w);
    write_reg(GMG_REG_DEPTH, d);
    write_reg(GMG_REG_ROWS, r);
    write_reg(GMG_REG_COLS, c);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    rows_eff = side_of(r);
    cols_eff = side_of(c);
  endtask

  // Mostly inside the grid, now and then on its edge or anywhere at all.
  function automatic int pick_coord(input int valid);
    int k;
    int v;
    k = $urandom_range(0, 19);
    if (k < 18) begin
      v = $urandom_range(0, valid - 1);
    end else if (k == 18) begin
      v = valid - 1 + $urandom_range(0, 1);
    end else begin
      v = $urandom_range(0, 1023);
    end
    if (v > 1023) v = 1023;
    return v;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [GMG_DIM_W-1:0] pick_count();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return GMG_DIM_W'($urandom_range(0, 1));
    if (k == 1) return GMG_DIM_W'($urandom_range(1025, 2047));
    if (k < 5) return GMG_DIM_W'($urandom_range(2, 16));
    return GMG_DIM_W'($urandom_range(2, 1024));
  endfunction

  task automatic random_requests(input int n);
    gmg_op_e op;
    bit      steady;
    int      lim_r;
    int      lim_c;
    steady = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) steady = ($urandom_range(0, 3) == 0);
      op    = gmg_op_e'($urandom_range(0, 1));
      lim_r = (op == GMG_OP_QUAD) ? rows_eff - 1 : rows_eff;
      lim_c = (op == GMG_OP_QUAD) ? cols_eff - 1 : cols_eff;
      send_request(op, pick_coord(lim_r), pick_coord(lim_c));
      if (!steady) pause(gap_len());
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset grid: two by two vertices, 256 units wide and deep.
    send_request(GMG_OP_VERTEX, 0, 0);
    send_request(GMG_OP_VERTEX, 1, 1);
    send_request(GMG_OP_VERTEX, 1, 0);
    send_request(GMG_OP_VERTEX, 2, 0);
    send_request(GMG_OP_VERTEX, 0, 1023);
    send_request(GMG_OP_QUAD, 0, 0);
    send_request(GMG_OP_QUAD, 1, 0);
    send_request(GMG_OP_QUAD, 0, 1);
    send_request(GMG_OP_QUAD, 1023, 1023);

    // Largest grid with the widest extents.
    load_grid(24'hFFFFFF, 24'hFFFFFF, 24'd1024, 24'd1024);
    send_request(GMG_OP_VERTEX, 1023, 1023);
    send_request(GMG_OP_VERTEX, 0, 0);
    send_request(GMG_OP_VERTEX, 1023, 0);
    send_request(GMG_OP_VERTEX, 511, 682);
    send_request(GMG_OP_QUAD, 1022, 1022);
    send_request(GMG_OP_QUAD, 0, 0);
    send_request(GMG_OP_QUAD, 1023, 0);
    random_requests(240);

    // Zero extents and counts below two, which must act as two.
    load_grid(24'd0, 24'd0, 24'd0, 24'd1);
    send_request(GMG_OP_VERTEX, 1, 1);
    send_request(GMG_OP_QUAD, 0, 0);
    send_request(GMG_OP_VERTEX, 2, 1);
    random_requests(150);

    // Counts above the maximum side, which must act as the maximum.
    load_grid(GMG_DIM_W'($urandom_range(0, 24'hFFFFFF)), 24'd1, 24'd2047, 24'd1025);
    random_requests(200);

    load_grid(24'd1, 24'hFFFFFF, 24'd3, 24'd1023);
    random_requests(200);

    for (int p = 0; p < 6; p++) begin
      load_grid(GMG_DIM_W'($urandom_range(0, 24'hFFFFFF)),
                GMG_DIM_W'($urandom_range(0, 24'hFFFFFF)),
                pick_count(), pick_count());
      random_requests(190);
    end

    settle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
